FILE: rtl/led_sweep_fade_animator_assert.svh
// Assertion macros used by the checker of the LED sweep animator.
`ifndef LED_SWEEP_FADE_ANIMATOR_ASSERT_SVH
`define LED_SWEEP_FADE_ANIMATOR_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low.
`define LSFA_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("led sweep check failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low.
`define LSFA_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("led sweep check failed");

`endif

FILE: rtl/lsfa_pkg.sv
`default_nettype none

package lsfa_pkg;

    localparam int LED_COUNT_DEF = 45;
    localparam int ELAPSED_W     = 16;
    localparam int COLOR_W       = 8;
    localparam int SLOT_W        = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    localparam logic [ELAPSED_W-1:0] ACC_KEEP_MAX = 16'd20;

    typedef logic [7:0] fade_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_SPEED  = 2'd1,
        CFG_BRIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic  shift;
        fade_t tail;
    } chain_ctl_t;

    function automatic fade_t decay(input fade_t v);
        fade_t r;
        if (v[7]) begin
            r = v - 8'd8;
        end else if (v[6]) begin
            r = v - 8'd6;
        end else if (v[5]) begin
            r = v - 8'd4;
        end else if (v[4]) begin
            r = v - 8'd3;
        end else if (v[3]) begin
            r = v - 8'd2;
        end else if (v != 8'd0) begin
            r = v - 8'd1;
        end else begin
            r = 8'd0;
        end
        return r;
    endfunction

    function automatic color_t scale8(input color_t c, input logic [7:0] l);
        logic [15:0] t;
        t = 16'(l) * 16'(c) + 16'(c);
        return t[15:8];
    endfunction

    function automatic logic [ELAPSED_W-1:0] pace_threshold(input logic [3:0] spd);
        logic [ELAPSED_W-1:0] r;
        case (spd)
            4'd0:    r = 16'd6;
            4'd1:    r = 16'd14;
            4'd3:    r = 16'd25;
            4'd4:    r = 16'd40;
            default: r = 16'd20;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] bright_value(input logic [2:0] bl);
        logic [7:0] r;
        case (bl)
            3'd0:    r = 8'd0;
            3'd1:    r = 8'd16;
            3'd2:    r = 8'd32;
            3'd3:    r = 8'd64;
            3'd4:    r = 8'd128;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/led_sweep_fade_animator.sv
`default_nettype none

// Power-on sweep and fade for a strip of LED_COUNT LEDs. Each tick word on the
// s_ side carries elapsed milliseconds and a base colour; while the sweep runs and
// is enabled, a tick that crosses the pacing threshold emits one frame of LED_COUNT
// words on the m_ side (slot, scaled colour, tlast on the final LED, tuser set on
// the last word of the frame that ends the sweep). Fade levels live in a ring of
// LED_COUNT cells that rotates by one cell per emitted LED, so a paced tick holds
// s_tready low until its whole frame has been emitted, and a stall on the m_ side
// holds emits back; each word passes two output stages (one per colour multiply).
// A tick that does not pace emits no frame. Reset clears the fade cells at once.
// Configuration writes are taken in every cycle.

module led_sweep_fade_animator #(
    parameter int LED_COUNT = lsfa_pkg::LED_COUNT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // elapsed_ms[15:0], base_red[23:16], base_green[31:24], base_blue[39:32]
    input  wire logic [39:0]                       s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // led_slot[5:0], red_out[13:6], green_out[21:14], blue_out[29:22], zero pad
    output logic [31:0]                            m_tdata,
    // frame_last
    output logic                                   m_tlast,
    // sweep_finished
    output logic                                   m_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lsfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lsfa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lsfa_pkg::*;

    localparam int IDX_W = $clog2(LED_COUNT);
    localparam int POS_W = $clog2(LED_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
    localparam logic [POS_W-1:0] POS_END  = POS_W'(LED_COUNT);

    logic                 enable_reg;
    logic [3:0]           speed_reg;
    logic [2:0]           bright_reg;

    state_t               state_reg,   state_next;
    logic [ELAPSED_W-1:0] acc_reg,     acc_next;
    logic [POS_W-1:0]     pos_reg,     pos_next;
    logic                 running_reg, running_next;
    logic [IDX_W-1:0]     idx_reg,     idx_next;
    logic                 set_en_reg,  set_en_next;
    logic [POS_W-1:0]     set_pos_reg, set_pos_next;
    logic                 s1_v_reg;
    logic                 m_v_reg;

    color_t               base_r_reg, base_g_reg, base_b_reg;
    logic [SLOT_W-1:0]    s1_slot_reg, m_slot_reg;
    color_t               s1_r_reg, s1_g_reg, s1_b_reg;
    color_t               m_r_reg, m_g_reg, m_b_reg;
    logic                 s1_last_reg, s1_fin_reg, m_last_reg, m_fin_reg;

    logic                 s_acc;
    logic [ELAPSED_W-1:0] acc_sum, thr, acc_diff;
    logic                 pace;
    logic                 adv_out, adv_s1, emit, is_last, fin;
    fade_t                head, fade_cur, fade_dec;
    logic [7:0]           bval;
    chain_ctl_t           chain_ctl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign acc_sum  = acc_reg + s_tdata[15:0];
    assign thr      = pace_threshold(speed_reg);
    assign acc_diff = acc_sum - thr;
    assign pace     = running_reg && enable_reg && (acc_sum > thr);

    assign adv_out  = !m_v_reg || m_tready;
    assign adv_s1   = !s1_v_reg || adv_out;
    assign emit     = (state_reg == ST_RUN) && adv_s1;
    assign is_last  = (idx_reg == LAST_IDX);
    assign fade_cur = (set_en_reg && (POS_W'(idx_reg) == set_pos_reg)) ? 8'hFF : head;
    assign fade_dec = decay(fade_cur);
    assign fin      = is_last && (fade_dec == 8'd1);
    assign bval     = bright_value(bright_reg);

    assign chain_ctl.shift = emit;
    assign chain_ctl.tail  = fade_dec;

    lsfa_chain #(
        .LED_COUNT (LED_COUNT)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (chain_ctl),
        .head    (head)
    );

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        running_next = running_reg;
        idx_next     = idx_reg;
        set_en_next  = set_en_reg;
        set_pos_next = set_pos_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    running_next = running_reg && enable_reg;
                    if (pace) begin
                        acc_next     = (acc_diff > ACC_KEEP_MAX) ? '0 : acc_diff;
                        state_next   = ST_RUN;
                        idx_next     = '0;
                        set_en_next  = (pos_reg < POS_END);
                        set_pos_next = pos_reg;
                        if (pos_reg < POS_END) begin
                            pos_next = pos_reg + POS_W'(1);
                        end
                    end else begin
                        acc_next = acc_sum;
                    end
                end
            end
            ST_RUN: begin
                if (emit) begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (is_last) begin
                        state_next = ST_IDLE;
                        if (fin) begin
                            running_next = 1'b0;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            pos_reg     <= '0;
            running_reg <= 1'b1;
            idx_reg     <= '0;
            set_en_reg  <= 1'b0;
            set_pos_reg <= '0;
            s1_v_reg    <= 1'b0;
            m_v_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            pos_reg     <= pos_next;
            running_reg <= running_next;
            idx_reg     <= idx_next;
            set_en_reg  <= set_en_next;
            set_pos_reg <= set_pos_next;
            if (adv_s1) begin
                s1_v_reg <= emit;
            end
            if (adv_out) begin
                m_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
            speed_reg  <= 4'd2;
            bright_reg <= 3'd5;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_SPEED:  speed_reg  <= cfg_data[3:0];
                CFG_BRIGHT: bright_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            base_r_reg <= s_tdata[23:16];
            base_g_reg <= s_tdata[31:24];
            base_b_reg <= s_tdata[39:32];
        end
        if (emit) begin
            s1_slot_reg <= SLOT_W'(idx_reg);
            s1_r_reg    <= scale8(base_r_reg, fade_cur);
            s1_g_reg    <= scale8(base_g_reg, fade_cur);
            s1_b_reg    <= scale8(base_b_reg, fade_cur);
            s1_last_reg <= is_last;
            s1_fin_reg  <= fin;
        end
        if (s1_v_reg && adv_out) begin
            m_slot_reg <= s1_slot_reg;
            m_r_reg    <= scale8(s1_r_reg, bval);
            m_g_reg    <= scale8(s1_g_reg, bval);
            m_b_reg    <= scale8(s1_b_reg, bval);
            m_last_reg <= s1_last_reg;
            m_fin_reg  <= s1_fin_reg;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = {2'b00, m_b_reg, m_g_reg, m_r_reg, m_slot_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_fin_reg;

endmodule

`default_nettype wire

FILE: rtl/lsfa_cell.sv
`default_nettype none

module lsfa_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          shift,
    input  wire lsfa_pkg::fade_t d_in,
    output lsfa_pkg::fade_t    q
);
    import lsfa_pkg::*;

    fade_t level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
        end else if (shift) begin
            level_reg <= d_in;
        end
    end

    assign q = level_reg;

endmodule

`default_nettype wire

FILE: rtl/lsfa_chain.sv
`default_nettype none

module lsfa_chain #(
    parameter int LED_COUNT = lsfa_pkg::LED_COUNT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire lsfa_pkg::chain_ctl_t ctl,
    output lsfa_pkg::fade_t           head
);
    import lsfa_pkg::*;

    fade_t lvl [LED_COUNT];

    for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
        fade_t d_in;
        if (i == LED_COUNT - 1) begin : g_tail
            assign d_in = ctl.tail;
        end else begin : g_mid
            assign d_in = lvl[i+1];
        end
        lsfa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (ctl.shift),
            .d_in    (d_in),
            .q       (lvl[i])
        );
    end

    assign head = lvl[0];

endmodule

`default_nettype wire

FILE: rtl/lsfa_checker.sv
`default_nettype none

`include "led_sweep_fade_animator_assert.svh"

module lsfa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    `LSFA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `LSFA_ASSERT_IMP(a_fin_on_last, m_tvalid && m_tuser, m_tlast)
    `LSFA_ASSERT_IMP(a_last_not_first, m_tvalid && m_tlast, m_tdata[5:0] != 6'd0)
    `LSFA_ASSERT_NXT(a_slot_step, m_tvalid && m_tready && !m_tlast,
        !m_tvalid || (m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1))

endmodule

bind led_sweep_fade_animator lsfa_checker u_lsfa_checker (.*);

`default_nettype wire

FILE: verif/led_sweep_fade_animator_tb.sv
`timescale 1ns / 100ps

module led_sweep_fade_animator_tb;
    import lsfa_pkg::*;

    localparam int LEDS        = LED_COUNT_DEF;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [ELAPSED_W-1:0] ms;
        color_t               red;
        color_t               green;
        color_t               blue;
    } tick_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        color_t            red;
        color_t            green;
        color_t            blue;
        logic              frame_end;
        logic              sweep_end;
    } led_word_t;

    typedef enum logic { ROW_TICK, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        tick_t                  tick;
        int                     frame_words;
    } plan_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [39:0]            s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    led_sweep_fade_animator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic                 run_enable = 1'b1;
    logic [3:0]           speed_reg  = 4'd2;
    logic [2:0]           bright_reg = 3'd5;
    logic [ELAPSED_W-1:0] tick_acc   = '0;
    logic [6:0]           next_led   = '0;
    logic                 sweep_live = 1'b1;
    fade_t                fade [LEDS];

    led_word_t pending_leds [$];
    led_word_t want_word;
    plan_row_t plan [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_done     = 0;
    int hold_count    = 0;
    int error_count   = 0;
    int words_seen    = 0;
    int ticks_sent    = 0;
    int frames_made   = 0;
    int sweep_ends    = 0;
    int cycles        = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [ELAPSED_W-1:0] pace_limit(input logic [3:0] lvl);
        logic [3:0] eff;
        eff = (lvl > 4'd4) ? 4'd2 : lvl;
        case (eff)
            4'd0:    return 16'd6;
            4'd1:    return 16'd14;
            4'd2:    return 16'd20;
            4'd3:    return 16'd25;
            default: return 16'd40;
        endcase
    endfunction

    function automatic logic [7:0] gain_of(input logic [2:0] lvl);
        logic [2:0] eff;
        eff = (lvl > 3'd5) ? 3'd5 : lvl;
        case (eff)
            3'd0:    return 8'd0;
            3'd1:    return 8'd16;
            3'd2:    return 8'd32;
            3'd3:    return 8'd64;
            3'd4:    return 8'd128;
            default: return 8'd255;
        endcase
    endfunction

    function automatic color_t dim(input color_t c, input logic [7:0] lvl);
        logic [16:0] prod;
        prod = {9'd0, lvl} * {9'd0, c} + {9'd0, c};
        return prod[15:8];
    endfunction

    function automatic fade_t fade_step(input fade_t v);
        casez (v)
            8'b1???????: return v - 8'd8;
            8'b01??????: return v - 8'd6;
            8'b001?????: return v - 8'd4;
            8'b0001????: return v - 8'd3;
            8'b00001???: return v - 8'd2;
            8'b00000000: return v;
            default:     return v - 8'd1;
        endcase
    endfunction

    task automatic advance_sweep(input tick_t t);
        logic [ELAPSED_W-1:0] limit;
        logic [7:0]           gain;
        logic                 ends_now;
        led_word_t            w;
        tick_acc = tick_acc + t.ms;
        if (!run_enable) begin
            sweep_live = 1'b0;
        end
        if (!sweep_live) return;
        limit = pace_limit(speed_reg);
        if (tick_acc <= limit) return;
        tick_acc = tick_acc - limit;
        if (tick_acc > ACC_KEEP_MAX) begin
            tick_acc = '0;
        end
        if (next_led < LEDS) begin
            fade[next_led] = 8'hFF;
            next_led++;
        end
        gain     = gain_of(bright_reg);
        ends_now = (fade_step(fade[LEDS-1]) == 8'd1);
        for (int i = 0; i < LEDS; i++) begin
            w.slot      = SLOT_W'(i);
            w.red       = dim(dim(t.red, fade[i]), gain);
            w.green     = dim(dim(t.green, fade[i]), gain);
            w.blue      = dim(dim(t.blue, fade[i]), gain);
            w.frame_end = (i == LEDS - 1);
            w.sweep_end = (i == LEDS - 1) && ends_now;
            pending_leds.push_back(w);
        end
        for (int i = 0; i < LEDS; i++) begin
            fade[i] = fade_step(fade[i]);
        end
        if (ends_now) begin
            sweep_live = 1'b0;
        end
        frames_made++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (m_tuser) begin
                sweep_ends++;
            end
            if (pending_leds.size() == 0) begin
                $error("unexpected LED word: tdata %0h tlast %0b tuser %0b",
                       m_tdata, m_tlast, m_tuser);
                error_count++;
            end else begin
                want_word = pending_leds.pop_front();
                check_field("led_slot", want_word.slot, m_tdata[5:0]);
                check_field("red_out", want_word.red, m_tdata[13:6]);
                check_field("green_out", want_word.green, m_tdata[21:14]);
                check_field("blue_out", want_word.blue, m_tdata[29:22]);
                check_field("frame_last", want_word.frame_end, m_tlast);
                check_field("sweep_finished", want_word.sweep_end, m_tuser);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_request != 0 && hold_done == 0) begin
            m_tready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_done = 1;
            end
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("led_sweep_fade_animator verification failed");
        $finish;
    end

    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.blue, t.green, t.red, t.ms};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
        advance_sweep(t);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_leds.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ENABLE: run_enable = value[0];
            CFG_SPEED:  speed_reg  = value;
            CFG_BRIGHT: bright_reg = value[2:0];
            default: ;
        endcase
    endtask

    function automatic plan_row_t tick_row(input logic [15:0] ms, input color_t r,
                                           input color_t g, input color_t b,
                                           input int words);
        plan_row_t row;
        row.kind        = ROW_TICK;
        row.reg_index   = '0;
        row.reg_value   = '0;
        row.tick.ms     = ms;
        row.tick.red    = r;
        row.tick.green  = g;
        row.tick.blue   = b;
        row.frame_words = words;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row             = tick_row(16'd0, 8'd0, 8'd0, 8'd0, -1);
        row.kind        = ROW_REG;
        row.reg_index   = idx;
        row.reg_value   = value;
        return row;
    endfunction

    function automatic color_t rand_color();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return 8'h00;
        if (pick < 30) return 8'hFF;
        return color_t'($urandom());
    endfunction

    // Bias toward ticks that land just over or under the current pacing threshold.
    function automatic tick_t random_tick();
        tick_t                t;
        int                   pick;
        int                   room;
        logic [ELAPSED_W-1:0] limit;
        limit   = pace_limit(speed_reg);
        room    = int'(limit) - int'(tick_acc);
        pick    = $urandom_range(99);
        t.red   = rand_color();
        t.green = rand_color();
        t.blue  = rand_color();
        if (pick < 8) begin
            t.ms = ELAPSED_W'($urandom());
        end else if (pick < 33) begin
            t.ms = (room >= 0) ? ELAPSED_W'(room + 1 + $urandom_range(30))
                               : ELAPSED_W'($urandom_range(30));
        end else begin
            t.ms = (room > 0) ? ELAPSED_W'($urandom_range(room)) : '0;
        end
        return t;
    endfunction

    task automatic run_random(input int count, input int pause_at);
        tick_t t;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) begin
                wait_drained();
            end
            t = random_tick();
            send_tick(t);
        end
    endtask

    initial begin
        int mark;
        for (int i = 0; i < LEDS; i++) begin
            fade[i] = '0;
        end

        plan.push_back(tick_row(16'd0,     8'hFF, 8'hFF, 8'hFF, 0));
        plan.push_back(tick_row(16'd20,    8'hFF, 8'h00, 8'hFF, 0));
        plan.push_back(tick_row(16'd1,     8'hFF, 8'hFF, 8'hFF, LEDS));
        plan.push_back(tick_row(16'hFFFF,  8'h00, 8'h00, 8'h00, 0));
        plan.push_back(tick_row(16'hFFFF,  8'h80, 8'h7F, 8'h01, LEDS));
        plan.push_back(reg_row(CFG_SPEED,  4'd0));
        plan.push_back(tick_row(16'd7,     8'hAA, 8'h55, 8'hAA, LEDS));
        plan.push_back(tick_row(16'd5,     8'h55, 8'hAA, 8'h55, 0));
        plan.push_back(tick_row(16'd26,    8'hFF, 8'h00, 8'h00, LEDS));
        plan.push_back(tick_row(16'd20,    8'h00, 8'hFF, 8'h00, LEDS));
        plan.push_back(tick_row(16'd0,     8'h00, 8'h00, 8'hFF, LEDS));
        plan.push_back(tick_row(16'd0,     8'h12, 8'h34, 8'h56, LEDS));
        plan.push_back(reg_row(CFG_SPEED,  4'd1));
        plan.push_back(reg_row(CFG_BRIGHT, 4'd0));
        plan.push_back(tick_row(16'd15,    8'hFF, 8'hFF, 8'hFF, LEDS));
        plan.push_back(reg_row(CFG_SPEED,  4'd3));
        plan.push_back(reg_row(CFG_BRIGHT, 4'd1));
        plan.push_back(tick_row(16'd30,    8'hC3, 8'h3C, 8'h99, -1));
        plan.push_back(reg_row(CFG_SPEED,  4'd4));
        plan.push_back(reg_row(CFG_BRIGHT, 4'd4));
        plan.push_back(tick_row(16'd40,    8'hFE, 8'h01, 8'h80, -1));
        plan.push_back(reg_row(CFG_SPEED,  4'd15));
        plan.push_back(reg_row(CFG_BRIGHT, 4'hF));
        plan.push_back(tick_row(16'd21,    8'h7F, 8'hFF, 8'h00, -1));
        plan.push_back(reg_row(CFG_BRIGHT, 4'd2));
        plan.push_back(reg_row(CFG_SPEED,  4'd5));
        plan.push_back(tick_row(16'd300,   8'hFF, 8'hFF, 8'hFF, -1));
        plan.push_back(reg_row(CFG_ENABLE, 4'hF));
        plan.push_back(reg_row(CFG_UNUSED, 4'hA));
        plan.push_back(tick_row(16'hFFFF,  8'hFF, 8'h00, 8'h00, -1));
        plan.push_back(reg_row(CFG_BRIGHT, 4'd6));
        plan.push_back(tick_row(16'd100,   8'h01, 8'h02, 8'h04, -1));

        send_idle_pct = 33;
        recv_idle_pct = 80;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end else begin
                mark = words_seen;
                send_tick(plan[i].tick);
                wait_drained();
                if (plan[i].frame_words >= 0 && words_seen - mark != plan[i].frame_words) begin
                    $error("words per tick: expected %0d, got %0d",
                           plan[i].frame_words, words_seen - mark);
                    error_count++;
                end
            end
        end

        write_reg(CFG_SPEED, 4'd0);
        write_reg(CFG_BRIGHT, 4'd3);
        run_random(140, 70);

        send_idle_pct = 80;
        recv_idle_pct = 33;
        write_reg(CFG_SPEED, 4'd3);
        write_reg(CFG_BRIGHT, 4'd5);
        run_random(140, -1);

        // hold the result side while ticks keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_SPEED, 4'd2);
        write_reg(CFG_BRIGHT, 4'd4);
        hold_request = 1;
        run_random(140, -1);

        // stop the sweep; re-enable must not restart it
        write_reg(CFG_ENABLE, 4'hE);
        run_random(6, -1);
        write_reg(CFG_ENABLE, 4'd1);
        run_random(4, -1);

        wait_drained();
        repeat (4 * SETTLE) @(posedge aclk);

        $display("run covered %0d ticks, %0d paced frames, %0d LED words, %0d sweep end(s)",
                 ticks_sent, frames_made, words_seen, sweep_ends);
        $display("speed and brightness swept through clamped levels, stall and disable paths hit");
        if (error_count == 0) begin
            $display("led_sweep_fade_animator verification clean");
        end else begin
            $display("led_sweep_fade_animator verification failed");
        end
        $finish;
    end

endmodule
